### sv/sjic_pkg.sv
// Shared types and constants for the stepper jog and index controller.
// No dependencies; every other file imports this package.
package sjic_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_STEP_INTERVAL  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PULSES_PER_REV = 1'b1;

  localparam logic [15:0] STEP_INTERVAL_RST  = 16'd1000;
  localparam logic [15:0] PULSES_PER_REV_RST = 16'd3200;

  localparam logic [8:0]         ANGLE_RST = 9'd10;
  localparam logic [8:0]         ANGLE_MAX = 9'd360;
  localparam logic signed [15:0] SPEED_RST = 16'sd60;
  localparam logic signed [15:0] ACCEL_RST = 16'sd10;
  localparam logic signed [15:0] SETTING_MIN = 16'sh8000;
  localparam logic signed [15:0] SETTING_MAX = 16'sh7fff;
  localparam logic [25:0]        DEG_PER_REV = 26'd360;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_KEY  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KEY_1 = 3'd0,
    KEY_2 = 3'd1,
    KEY_3 = 3'd2,
    KEY_4 = 3'd3,
    KEY_A = 3'd4,
    KEY_B = 3'd5,
    KEY_C = 3'd6,
    KEY_D = 3'd7
  } key_e;

  typedef enum logic [1:0] {
    MENU_MAIN  = 2'd0,
    MENU_SPEED = 2'd1,
    MENU_ACCEL = 2'd2,
    MENU_ANGLE = 2'd3
  } menu_e;

  typedef struct packed {
    logic       cmd;
    logic [2:0] key_code;
  } item_t;

  typedef struct packed {
    logic               step_out;
    logic               dir_out;
    logic [1:0]         menu_page;
    logic               run_flag;
    logic               jump_flag;
    logic               hold_flag;
    logic               dir_flag;
    logic [8:0]         jump_degrees;
    logic signed [15:0] speed_value;
    logic signed [15:0] accel_value;
  } result_t;

  typedef struct packed {
    logic [15:0] step_interval;
    logic [15:0] pulses_per_rev;
  } cfg_t;

endpackage

### sv/sjic_if.sv
// Valid/ready channel interfaces for key/tick items and results.
// Depends on sjic_pkg for the payload types.
interface sjic_in_if import sjic_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sjic_out_if import sjic_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/sjic_core.sv
// Controller state and single-pass next-state logic for one item.
// Depends on sjic_pkg; the top level supplies the item, configuration and advance.
module sjic_core import sjic_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [15:0]        elapsed_q, elapsed_d;
  logic               step_q, step_d;
  logic               dirlvl_q, dirlvl_d;
  logic [16:0]        jtog_q, jtog_d;
  menu_e              menu_q, menu_d;
  logic               run_q, run_d;
  logic               jump_q, jump_d;
  logic               hold_q, hold_d;
  logic               dir_q, dir_d;
  logic [8:0]         angle_q, angle_d;
  logic signed [15:0] speed_q, speed_d;
  logic signed [15:0] accel_q, accel_d;

  logic [16:0] elapsed_inc;
  logic [15:0] elapsed_sat;
  logic [16:0] jtog_inc;
  logic [25:0] jtog_deg;
  logic [24:0] pulse_deg;
  logic        dec, inc;

  assign pulse_deg = 25'(angle_q) * 25'(cfg_i.pulses_per_rev);

  always_comb begin
    elapsed_d = elapsed_q;
    step_d    = step_q;
    dirlvl_d  = dirlvl_q;
    jtog_d    = jtog_q;
    menu_d    = menu_q;
    run_d     = run_q;
    jump_d    = jump_q;
    hold_d    = hold_q;
    dir_d     = dir_q;
    angle_d   = angle_q;
    speed_d   = speed_q;
    accel_d   = accel_q;
    dec       = 1'b0;
    inc       = 1'b0;

    elapsed_inc = {1'b0, elapsed_q} + 17'd1;
    elapsed_sat = (elapsed_inc > {1'b0, cfg_i.step_interval}) ? cfg_i.step_interval
                                                               : elapsed_inc[15:0];
    jtog_inc    = jump_q ? (jtog_q + 17'd1) : jtog_q;
    jtog_deg    = 26'(jtog_inc) * DEG_PER_REV;

    if (cmd_e'(item_i.cmd) == CMD_KEY) begin
      case (key_e'(item_i.key_code))
        KEY_1:   menu_d = (menu_q == MENU_ANGLE) ? MENU_SPEED : menu_e'(menu_q + 2'd1);
        KEY_2:   dec    = 1'b1;
        KEY_3:   inc    = 1'b1;
        KEY_4:   menu_d = MENU_MAIN;
        KEY_A:   dir_d  = ~dir_q;
        KEY_B:   run_d  = ~run_q;
        KEY_C:   jump_d = 1'b1;
        KEY_D:   hold_d = ~hold_q;
        default: hold_d = hold_q;
      endcase
      case (menu_q)
        MENU_SPEED: begin
          if (dec && speed_q != SETTING_MIN) speed_d = speed_q - 16'sd1;
          if (inc && speed_q != SETTING_MAX) speed_d = speed_q + 16'sd1;
        end
        MENU_ACCEL: begin
          if (dec && accel_q != SETTING_MIN) accel_d = accel_q - 16'sd1;
          if (inc && accel_q != SETTING_MAX) accel_d = accel_q + 16'sd1;
        end
        MENU_ANGLE: begin
          if (dec && angle_q != 9'd0) angle_d = angle_q - 9'd1;
          if (inc && angle_q < ANGLE_MAX) angle_d = angle_q + 9'd1;
        end
        default: angle_d = angle_q;
      endcase
    end else begin
      elapsed_d = elapsed_sat;
      if ((run_q || jump_q) && elapsed_sat >= cfg_i.step_interval) begin
        elapsed_d = 16'd0;
        dirlvl_d  = dir_q;
        step_d    = ~step_q;
        // toggles exceed floor(P/360) exactly when 360*toggles > P
        if (jtog_deg > {1'b0, pulse_deg}) begin
          jtog_d = 17'd0;
          jump_d = 1'b0;
        end else begin
          jtog_d = jtog_inc;
        end
      end
    end
  end

  always_comb begin
    res_o.step_out     = (run_d || jump_d) ? step_d : hold_d;
    res_o.dir_out      = dirlvl_d;
    res_o.menu_page    = menu_d;
    res_o.run_flag     = run_d;
    res_o.jump_flag    = jump_d;
    res_o.hold_flag    = hold_d;
    res_o.dir_flag     = dir_d;
    res_o.jump_degrees = angle_d;
    res_o.speed_value  = speed_d;
    res_o.accel_value  = accel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      step_q    <= 1'b0;
      dirlvl_q  <= 1'b0;
      jtog_q    <= '0;
      menu_q    <= MENU_MAIN;
      run_q     <= 1'b0;
      jump_q    <= 1'b0;
      hold_q    <= 1'b0;
      dir_q     <= 1'b1;
      angle_q   <= ANGLE_RST;
      speed_q   <= SPEED_RST;
      accel_q   <= ACCEL_RST;
    end else if (adv_i) begin
      elapsed_q <= elapsed_d;
      step_q    <= step_d;
      dirlvl_q  <= dirlvl_d;
      jtog_q    <= jtog_d;
      menu_q    <= menu_d;
      run_q     <= run_d;
      jump_q    <= jump_d;
      hold_q    <= hold_d;
      dir_q     <= dir_d;
      angle_q   <= angle_d;
      speed_q   <= speed_d;
      accel_q   <= accel_d;
    end
  end

endmodule

### sv/stepper_jog_index_controller.sv
// Stepper jog and index controller top level: input register, core, result register.
// The core state updates in a single pass per item; results wait in the result register.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset: asynchronous, active low; clears both stages and loads the power-on settings.
// Depends on sjic_pkg, sjic_in_if, sjic_out_if and sjic_core.
module stepper_jog_index_controller import sjic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  sjic_in_if.sink             in_chan_i,
  sjic_out_if.source          out_chan_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t res_q, res_d;
  cfg_t    cfg_q;
  logic    adv;

  assign adv             = s1_valid_q && (!out_valid_q || out_chan_o.ready);
  assign in_chan_i.ready = !s1_valid_q || adv;
  assign out_chan_o.valid = out_valid_q;
  assign out_chan_o.data  = res_q;

  sjic_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_interval  <= STEP_INTERVAL_RST;
      cfg_q.pulses_per_rev <= PULSES_PER_REV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_INTERVAL:  cfg_q.step_interval  <= cfg_wdata_i;
        REG_PULSES_PER_REV: cfg_q.pulses_per_rev <= cfg_wdata_i;
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_chan_i.ready) s1_valid_q <= in_chan_i.valid;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan_i.valid && in_chan_i.ready) s1_item_q <= in_chan_i.data;
    if (adv) res_q <= res_d;
  end

  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.run_flag && !res_q.jump_flag |-> res_q.step_out == res_q.hold_flag)
    else $error("idle step level differs from hold flag");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.jump_degrees <= ANGLE_MAX)
    else $error("jump angle above full turn");

  a_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan_i.valid && in_chan_i.ready |=> s1_valid_q)
    else $error("transferred item lost in input register");

  a_result_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced item gave no result");

endmodule

### sim/stepper_jog_index_controller_test.sv
// Self-checking testbench for the stepper jog and index controller.
// Drives ticks and key presses over the valid/ready channels and checks every result.
// Depends on sjic_pkg, sjic_in_if, sjic_out_if and stepper_jog_index_controller.
module stepper_jog_index_controller_test;
  import sjic_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic    typed;
    item_t   stim;
    result_t pins;
  } script_row_t;

  typedef struct packed {
    logic [15:0] interval;
    logic [15:0] pulses;
    logic [15:0] items;
    logic        quiet;
  } phase_t;

  localparam result_t POWER_ON = '{1'b0, 1'b0, MENU_MAIN, 1'b0, 1'b0, 1'b0, 1'b1,
                                   ANGLE_RST, SPEED_RST, ACCEL_RST};
  localparam result_t HOLD_IDLE = '{1'b1, 1'b0, MENU_MAIN, 1'b0, 1'b0, 1'b1, 1'b1,
                                    ANGLE_RST, SPEED_RST, ACCEL_RST};

  localparam int unsigned SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b1, '{CMD_TICK, KEY_1}, POWER_ON},
    '{1'b1, '{CMD_KEY,  KEY_2}, POWER_ON},
    '{1'b1, '{CMD_KEY,  KEY_3}, POWER_ON},
    '{1'b1, '{CMD_KEY,  KEY_D}, HOLD_IDLE},
    '{1'b0, '{CMD_KEY,  KEY_D}, '0},
    '{1'b0, '{CMD_KEY,  KEY_1}, '0},
    '{1'b0, '{CMD_KEY,  KEY_3}, '0},
    '{1'b0, '{CMD_KEY,  KEY_2}, '0},
    '{1'b0, '{CMD_KEY,  KEY_2}, '0},
    '{1'b0, '{CMD_KEY,  KEY_1}, '0},
    '{1'b0, '{CMD_KEY,  KEY_3}, '0},
    '{1'b0, '{CMD_KEY,  KEY_2}, '0},
    '{1'b0, '{CMD_KEY,  KEY_1}, '0},
    '{1'b0, '{CMD_KEY,  KEY_3}, '0},
    '{1'b0, '{CMD_KEY,  KEY_2}, '0},
    '{1'b0, '{CMD_KEY,  KEY_1}, '0},
    '{1'b0, '{CMD_KEY,  KEY_4}, '0},
    '{1'b0, '{CMD_KEY,  KEY_A}, '0},
    '{1'b0, '{CMD_KEY,  KEY_B}, '0},
    '{1'b0, '{CMD_TICK, KEY_D}, '0},
    '{1'b0, '{CMD_KEY,  KEY_C}, '0},
    '{1'b0, '{CMD_KEY,  KEY_C}, '0},
    '{1'b0, '{CMD_KEY,  KEY_B}, '0},
    '{1'b0, '{CMD_KEY,  KEY_D}, '0},
    '{1'b0, '{CMD_TICK, KEY_4}, '0}
  };

  localparam int unsigned PHASE_CNT = 7;
  localparam phase_t PHASES [PHASE_CNT] = '{
    '{16'd1,     16'd1,     16'd200, 1'b0},
    '{16'd0,     16'd0,     16'd150, 1'b0},
    '{16'd2,     16'd360,   16'd200, 1'b0},
    '{16'd3,     16'd100,   16'd200, 1'b0},
    '{16'd1,     16'd65535, 16'd150, 1'b0},
    '{16'd65535, 16'd3200,  16'd100, 1'b0},
    '{16'd4,     16'd7,     16'd250, 1'b1}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  sjic_in_if  in_chan ();
  sjic_out_if out_chan ();

  stepper_jog_index_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan_i   (in_chan),
    .out_chan_o  (out_chan),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  logic [15:0]        interval_reg;
  logic [15:0]        pulses_reg;
  logic [15:0]        elapsed_cnt;
  logic               step_lvl;
  logic               dir_lvl;
  logic [16:0]        jump_cnt;
  menu_e              menu_pg;
  logic               run_on;
  logic               jump_on;
  logic               hold_on;
  logic               dir_sel;
  logic [8:0]         angle_deg;
  logic signed [15:0] speed_dps;
  logic signed [15:0] accel_dps;

  result_t     pin_forecast_q [$];
  logic        script_typed;
  result_t     script_pins;
  bit          src_idle_en;
  bit          sink_stall_en;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned settings_loaded;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic result_t advance_controller(item_t it);
    result_t     r;
    int          delta;
    logic [16:0] nxt;
    logic [31:0] limit;
    delta = 0;
    if (it.cmd == CMD_KEY) begin
      case (key_e'(it.key_code))
        KEY_1: menu_pg = (menu_pg == MENU_ANGLE) ? MENU_SPEED : menu_e'(menu_pg + 2'd1);
        KEY_2: delta = -1;
        KEY_3: delta = 1;
        KEY_4: menu_pg = MENU_MAIN;
        KEY_A: dir_sel = ~dir_sel;
        KEY_B: run_on = ~run_on;
        KEY_C: jump_on = 1'b1;
        default: hold_on = ~hold_on;
      endcase
      if (delta != 0) begin
        case (menu_pg)
          MENU_SPEED: speed_dps = 16'(clamp(int'(speed_dps) + delta, int'(SETTING_MIN),
                                            int'(SETTING_MAX)));
          MENU_ACCEL: accel_dps = 16'(clamp(int'(accel_dps) + delta, int'(SETTING_MIN),
                                            int'(SETTING_MAX)));
          MENU_ANGLE: angle_deg = 9'(clamp(int'(angle_deg) + delta, 0, int'(ANGLE_MAX)));
          default: ;
        endcase
      end
    end else begin
      nxt = {1'b0, elapsed_cnt} + 17'd1;
      elapsed_cnt = (nxt > {1'b0, interval_reg}) ? interval_reg : nxt[15:0];
      if ((run_on || jump_on) && elapsed_cnt >= interval_reg) begin
        elapsed_cnt = '0;
        dir_lvl = dir_sel;
        step_lvl = ~step_lvl;
        if (jump_on) jump_cnt = jump_cnt + 17'd1;
        limit = (32'(angle_deg) * 32'(pulses_reg)) / 32'(DEG_PER_REV);
        if (32'(jump_cnt) > limit) begin
          jump_cnt = '0;
          jump_on = 1'b0;
        end
      end
    end
    r.step_out     = (run_on || jump_on) ? step_lvl : hold_on;
    r.dir_out      = dir_lvl;
    r.menu_page    = menu_pg;
    r.run_flag     = run_on;
    r.jump_flag    = jump_on;
    r.hold_flag    = hold_on;
    r.dir_flag     = dir_sel;
    r.jump_degrees = angle_deg;
    r.speed_value  = speed_dps;
    r.accel_value  = accel_dps;
    return r;
  endfunction

  task automatic compare_pins(result_t want, result_t got);
    if (got.step_out !== want.step_out) begin
      $error("step_out: expected %0d, got %0d", want.step_out, got.step_out);
      mismatches++;
    end
    if (got.dir_out !== want.dir_out) begin
      $error("dir_out: expected %0d, got %0d", want.dir_out, got.dir_out);
      mismatches++;
    end
    if (got.menu_page !== want.menu_page) begin
      $error("menu_page: expected %0d, got %0d", want.menu_page, got.menu_page);
      mismatches++;
    end
    if (got.run_flag !== want.run_flag) begin
      $error("run_flag: expected %0d, got %0d", want.run_flag, got.run_flag);
      mismatches++;
    end
    if (got.jump_flag !== want.jump_flag) begin
      $error("jump_flag: expected %0d, got %0d", want.jump_flag, got.jump_flag);
      mismatches++;
    end
    if (got.hold_flag !== want.hold_flag) begin
      $error("hold_flag: expected %0d, got %0d", want.hold_flag, got.hold_flag);
      mismatches++;
    end
    if (got.dir_flag !== want.dir_flag) begin
      $error("dir_flag: expected %0d, got %0d", want.dir_flag, got.dir_flag);
      mismatches++;
    end
    if (got.jump_degrees !== want.jump_degrees) begin
      $error("jump_degrees: expected %0d, got %0d", want.jump_degrees, got.jump_degrees);
      mismatches++;
    end
    if (got.speed_value !== want.speed_value) begin
      $error("speed_value: expected %0d, got %0d", want.speed_value, got.speed_value);
      mismatches++;
    end
    if (got.accel_value !== want.accel_value) begin
      $error("accel_value: expected %0d, got %0d", want.accel_value, got.accel_value);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (in_chan.valid && in_chan.ready) begin
        want = advance_controller(in_chan.data);
        if (script_typed) want = script_pins;
        pin_forecast_q.push_back(want);
        items_sent++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pin_forecast_q.size() == 0) begin
          $error("result transfer with no result outstanding");
          mismatches++;
        end else begin
          compare_pins(pin_forecast_q.pop_front(), out_chan.data);
          results_checked++;
        end
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin : result_sink
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_chan.ready <= 1'b1;
    end
  end

  task automatic send(item_t it, logic typed, result_t pins);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    script_typed  <= typed;
    script_pins   <= pins;
    do @(posedge clk_i); while (!in_chan.ready);
  endtask

  task automatic press_repeatedly(key_e k, int unsigned count);
    repeat (count) send('{CMD_KEY, k}, 1'b0, '0);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_chan.valid <= 1'b0;
    script_typed  <= 1'b0;
    while (pin_forecast_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [15:0] interval, logic [15:0] pulses);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_STEP_INTERVAL;
    cfg_wdata <= interval;
    @(negedge clk_i);
    cfg_idx   <= REG_PULSES_PER_REV;
    cfg_wdata <= pulses;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    interval_reg = interval;
    pulses_reg   = pulses;
    settings_loaded++;
  endtask

  initial begin : stimulus
    item_t it;
    rst_ni          = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.data    = '0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    script_typed    = 1'b0;
    script_pins     = '0;
    src_idle_en     = 1'b1;
    sink_stall_en   = 1'b1;
    idle_cycles     = 0;
    items_sent      = 0;
    results_checked = 0;
    settings_loaded = 0;
    mismatches      = 0;
    interval_reg    = STEP_INTERVAL_RST;
    pulses_reg      = PULSES_PER_REV_RST;
    elapsed_cnt     = '0;
    step_lvl        = 1'b0;
    dir_lvl         = 1'b0;
    jump_cnt        = '0;
    menu_pg         = MENU_MAIN;
    run_on          = 1'b0;
    jump_on         = 1'b0;
    hold_on         = 1'b0;
    dir_sel         = 1'b1;
    angle_deg       = ANGLE_RST;
    speed_dps       = SPEED_RST;
    accel_dps       = ACCEL_RST;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (SCRIPT[i]) send(SCRIPT[i].stim, SCRIPT[i].typed, SCRIPT[i].pins);
    settle();

    // step speed and acceleration both ways, drive the jump angle into both limits
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    press_repeatedly(KEY_4, 1);
    press_repeatedly(KEY_1, 1);
    press_repeatedly(KEY_3, 5);
    press_repeatedly(KEY_2, 8);
    press_repeatedly(KEY_1, 1);
    press_repeatedly(KEY_3, 5);
    press_repeatedly(KEY_2, 8);
    press_repeatedly(KEY_1, 1);
    press_repeatedly(KEY_2, 15);
    press_repeatedly(KEY_3, 365);
    press_repeatedly(KEY_4, 1);
    settle();

    foreach (PHASES[p]) begin
      load_regs(PHASES[p].interval, PHASES[p].pulses);
      src_idle_en   = !PHASES[p].quiet;
      sink_stall_en = !PHASES[p].quiet;
      repeat (PHASES[p].items) begin
        it.cmd      = ($urandom_range(0, 9) < 3) ? CMD_KEY : CMD_TICK;
        it.key_code = 3'($urandom_range(0, 7));
        send(it, 1'b0, '0);
      end
      settle();
    end

    $display("covered %0d transfers, %0d results checked, %0d register settings, %0d mismatches",
             items_sent, results_checked, settings_loaded, mismatches);
    if (mismatches == 0 && pin_forecast_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
